FILE: rtl/core/mdps_pkg.sv
// Shared types and constants for the masked descending momentum sorter.
// No dependencies; imported by mdps_cell and masked_descending_pt_sorter.
`default_nettype none

package mdps_pkg;

   localparam int MOM_W               = 24;
   localparam int POS_W               = 6;
   localparam int DEFAULT_MAX_OBJECTS = 64;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic             insert;
      logic             shift;
      logic [MOM_W-1:0] mom;
      logic [POS_W-1:0] pos;
   } cell_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/core/mdps_cell.sv
// One slot of the sorting chain: holds a momentum and its position.
// Depends on mdps_pkg for widths and the command struct.
`default_nettype none

module mdps_cell
   import mdps_pkg::*;
(
   input  wire logic             clock,
   input  wire cell_cmd_type     cmd,
   input  wire logic             occ,       // this slot holds a kept item
   input  wire logic             prev_hold, // upper neighbor keeps its item
   input  wire logic [MOM_W-1:0] prev_mom,
   input  wire logic [POS_W-1:0] prev_pos,
   input  wire logic [MOM_W-1:0] next_mom,
   input  wire logic [POS_W-1:0] next_pos,
   output logic                  hold,
   output logic      [MOM_W-1:0] mom,
   output logic      [POS_W-1:0] pos
);

   logic [MOM_W-1:0] mom_ff, mom_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   // stored item stays ahead on equal momentum
   assign hold = occ && (mom_ff >= cmd.mom);

   always_comb begin
      mom_in = mom_ff;
      pos_in = pos_ff;
      if (cmd.insert) begin
         if (!hold) begin
            if (prev_hold) begin
               mom_in = cmd.mom;
               pos_in = cmd.pos;
            end else begin
               mom_in = prev_mom;
               pos_in = prev_pos;
            end
         end
      end else if (cmd.shift) begin
         mom_in = next_mom;
         pos_in = next_pos;
      end
   end

   always_ff @(posedge clock) begin
      mom_ff <= mom_in;
      pos_ff <= pos_in;
   end

   assign mom = mom_ff;
   assign pos = pos_ff;

endmodule

`default_nettype wire

FILE: rtl/core/masked_descending_pt_sorter.sv
// Top level of the masked descending momentum sorter: control and cell chain.
// Depends on mdps_pkg and mdps_cell.
//
// Usage:
//   req channel: one object per item. req_tdata carries the momentum,
//   req_tuser the three pass flags, req_tlast marks the last object of
//   the event. Objects whose flags are all set are kept; objects past
//   MAX_OBJECTS are dropped and flag the event as overflowed.
//   Loading takes one item per cycle: each kept item is inserted in place
//   in a chain of MAX_OBJECTS cells, every cell comparing its own entry to
//   the new momentum and taking the new item or its upper neighbor's.
//   After the item with req_tlast the block stops taking items and drains:
//   the first result is valid the next cycle, then, while rsp_tready is high,
//   one result per cycle as the chain shifts toward cell 0, highest momentum
//   first, equal momenta by lower position. An event with K kept items gives
//   K results (one empty-flagged result when K is zero); req_tready returns
//   the cycle after the last result is taken.
//   A stall on rsp_tready holds the current result and the chain.
//   Reset (synchronous, active high) empties the chain and returns to load.
`default_nettype none

module masked_descending_pt_sorter
   import mdps_pkg::*;
#(
   parameter int MAX_OBJECTS = DEFAULT_MAX_OBJECTS
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // [23:0] momentum
   input  wire logic [2:0]  req_tuser,  // [0] pass_a, [1] pass_b, [2] pass_c
   input  wire logic        req_tlast,  // final_item
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // [5:0] position, [29:6] momentum_out, rest zero
   output logic      [1:0]  rsp_tuser,  // [0] empty_res, [1] overflow
   output logic             rsp_tlast   // run_end
);

   localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_OBJECTS);

   typedef enum logic {ST_LOAD, ST_DRAIN} state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] kept_ff, items_ff;
   logic             ovf_ff;

   logic req_acc, rsp_acc, keep, room, last_rsp;
   cell_cmd_type cmd;

   logic             hold_w [MAX_OBJECTS];
   logic [MOM_W-1:0] mom_w  [MAX_OBJECTS];
   logic [POS_W-1:0] pos_w  [MAX_OBJECTS];

   assign req_tready = (state_ff == ST_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_DRAIN);
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   assign keep     = req_tuser[0] && req_tuser[1] && req_tuser[2];
   assign room     = (items_ff < CAP);
   assign last_rsp = (kept_ff <= CNT_W'(1));

   always_comb begin
      cmd.insert = req_acc && room && keep;
      cmd.shift  = rsp_acc && !last_rsp;
      cmd.mom    = req_tdata[MOM_W-1:0];
      cmd.pos    = POS_W'(items_ff);
   end

   // chain of cells; cell 0 holds the largest momentum
   for (genvar i = 0; i < MAX_OBJECTS; i++) begin : g_cell
      logic             occ, prev_hold;
      logic [MOM_W-1:0] prev_mom, next_mom;
      logic [POS_W-1:0] prev_pos, next_pos;

      assign occ = (CNT_W'(i) < kept_ff);

      if (i == 0) begin : g_head
         assign prev_hold = 1'b1;
         assign prev_mom  = cmd.mom;
         assign prev_pos  = cmd.pos;
      end else begin : g_body
         assign prev_hold = hold_w[i-1];
         assign prev_mom  = mom_w[i-1];
         assign prev_pos  = pos_w[i-1];
      end

      if (i == MAX_OBJECTS - 1) begin : g_tail
         assign next_mom = mom_w[i];
         assign next_pos = pos_w[i];
      end else begin : g_mid
         assign next_mom = mom_w[i+1];
         assign next_pos = pos_w[i+1];
      end

      mdps_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occ       (occ),
         .prev_hold (prev_hold),
         .prev_mom  (prev_mom),
         .prev_pos  (prev_pos),
         .next_mom  (next_mom),
         .next_pos  (next_pos),
         .hold      (hold_w[i]),
         .mom       (mom_w[i]),
         .pos       (pos_w[i])
      );
   end

   // control: load, then drain the chain head one result at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         kept_ff  <= '0;
         items_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (req_acc) begin
                  if (room) begin
                     items_ff <= items_ff + CNT_W'(1);
                     if (keep) begin
                        kept_ff <= kept_ff + CNT_W'(1);
                     end
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_tlast) begin
                     state_ff <= ST_DRAIN;
                  end
               end
            end
            ST_DRAIN: begin
               if (rsp_acc) begin
                  if (last_rsp) begin
                     state_ff <= ST_LOAD;
                     kept_ff  <= '0;
                     items_ff <= '0;
                     ovf_ff   <= 1'b0;
                  end else begin
                     kept_ff <= kept_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   // empty event: one result with zero payload
   logic empty_w;
   assign empty_w = (kept_ff == '0);

   always_comb begin
      rsp_tdata = '0;
      if (!empty_w) begin
         rsp_tdata[POS_W-1:0]       = pos_w[0];
         rsp_tdata[POS_W+MOM_W-1:POS_W] = mom_w[0];
      end
      rsp_tuser = {ovf_ff, empty_w};
      rsp_tlast = last_rsp;
   end

   a_final_drains: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast |=> rsp_tvalid)
      else $error("no result after final item");

   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= items_ff && items_ff <= CAP)
      else $error("kept count exceeds item count or capacity");

   a_drain_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_tlast |=> req_tready && kept_ff == '0 && !ovf_ff)
      else $error("event state not cleared after last result");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> mom_w[0] >= mom_w[1])
      else $error("chain head out of descending order");

endmodule

`default_nettype wire
